/* sv/wanp_pkg.sv */
package wanp_pkg;

  // Table depth used when the top level is not told otherwise.
  localparam int ENTRIES_DEFAULT = 10;

  // Calendar constants.
  localparam int WEEK_MINUTES  = 10080;
  localparam int DAY_MINUTES   = 1440;
  localparam int DAYS_PER_WEEK = 7;

  // Field widths of the request and result channels.
  localparam int ACTION_W  = 2;
  localparam int INDEX_W   = 4;
  localparam int HOUR_W    = 5;
  localparam int MINUTE_W  = 6;
  localparam int DAYS_W    = 7;
  localparam int WEEKDAY_W = 3;
  localparam int STATUS_W  = 2;
  localparam int TOTAL_W   = 4;
  localparam int DELTA_W   = 14;
  localparam int TOD_W     = 11;
  localparam int RAW_W     = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_QUERY      = 2'd0,
    ACT_ADD        = 2'd1,
    ACT_DELETE     = 2'd2,
    ACT_SET_ENABLE = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_BAD_INDEX = 2'd2
  } status_t;

  // One stored alarm, 20 bits.
  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [DAYS_W-1:0]   repeat_days;
    logic                once;
    logic                enable;
  } slot_t;

  // Minute of the day, hour * 60 + minute, built from shifts.
  function automatic logic [TOD_W-1:0] tod(input logic [HOUR_W-1:0] h,
                                           input logic [MINUTE_W-1:0] m);
    logic [TOD_W-1:0] hx;
    hx = TOD_W'(h);
    return (hx << 6) - (hx << 2) + TOD_W'(m);
  endfunction

  // Minutes in a number of whole days, 0 to 7.
  function automatic logic [DELTA_W-1:0] day_offset(input logic [WEEKDAY_W-1:0] days);
    return DELTA_W'(int'(days) * DAY_MINUTES);
  endfunction

endpackage

/* sv/wanp_in_if.sv */
interface wanp_in_if;
  logic                               valid;
  logic                               ready;
  logic [wanp_pkg::ACTION_W-1:0]      action;
  logic [wanp_pkg::INDEX_W-1:0]       entry_index;
  logic [wanp_pkg::HOUR_W-1:0]        new_hour;
  logic [wanp_pkg::MINUTE_W-1:0]      new_minute;
  logic [wanp_pkg::DAYS_W-1:0]        new_repeat_days;
  logic                               new_once;
  logic                               enable_flag;
  logic [wanp_pkg::WEEKDAY_W-1:0]     now_weekday;
  logic [wanp_pkg::HOUR_W-1:0]        now_hour;
  logic [wanp_pkg::MINUTE_W-1:0]      now_minute;

  modport source (
    output valid, action, entry_index, new_hour, new_minute, new_repeat_days,
           new_once, enable_flag, now_weekday, now_hour, now_minute,
    input  ready
  );

  modport sink (
    input  valid, action, entry_index, new_hour, new_minute, new_repeat_days,
           new_once, enable_flag, now_weekday, now_hour, now_minute,
    output ready
  );
endinterface

/* sv/wanp_out_if.sv */
interface wanp_out_if;
  logic                               valid;
  logic                               ready;
  logic [wanp_pkg::STATUS_W-1:0]      status;
  logic [wanp_pkg::TOTAL_W-1:0]       alarm_total;
  logic                               next_found;
  logic [wanp_pkg::INDEX_W-1:0]       next_index;
  logic [wanp_pkg::WEEKDAY_W-1:0]     next_weekday;
  logic [wanp_pkg::HOUR_W-1:0]        next_hour;
  logic [wanp_pkg::MINUTE_W-1:0]      next_minute;
  logic [wanp_pkg::DELTA_W-1:0]       minutes_until;

  modport source (
    output valid, status, alarm_total, next_found, next_index, next_weekday,
           next_hour, next_minute, minutes_until,
    input  ready
  );

  modport sink (
    input  valid, status, alarm_total, next_found, next_index, next_weekday,
           next_hour, next_minute, minutes_until,
    output ready
  );
endinterface

/* sv/weekly_alarm_next_picker_top.sv */
// Weekly alarm table with a next-alarm picker.
// Requests arrive on in_ch (valid/ready). Each request carries an action
// (query, add, delete, set enable), its operands and the current time.
// Exactly one result leaves on out_ch (valid/ready) for every request: a
// status, the alarm count and the soonest enabled alarm with minutes until.
// in_ch.ready is high only while the sequencer is idle; one request is
// worked on at a time. After the accepting edge the sequencer passes the
// action step, then scans the alarms held after the action: for each one
// it reads the table entry and then evaluates it, through the single table
// read port and the shared due-time unit. The next request is taken in the
// cycle after the load at the earliest. Set enable adds a read-modify-write
// step, and delete adds a read step and a write step for every entry that
// shifts down.
// A finished result waits in the output register; if the receiver stalls
// and the next request finishes too, the sequencer holds until the
// register is free. Reset empties the table (count zero), clears the
// output valid and makes the block ready; the table contents need no
// clearing.
module weekly_alarm_next_picker_top #(
  parameter int ENTRIES = wanp_pkg::ENTRIES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  wanp_in_if.sink     in_ch,
  wanp_out_if.source  out_ch
);

  localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = ((CNT_W > wanp_pkg::INDEX_W) ? CNT_W : wanp_pkg::INDEX_W) + 1;
  localparam logic signed [wanp_pkg::RAW_W-1:0] WEEK_S =
    wanp_pkg::RAW_W'(wanp_pkg::WEEK_MINUTES);
  localparam int WEEKDAY_LAST_W = wanp_pkg::WEEKDAY_W;
  localparam logic [WEEKDAY_LAST_W-1:0] SUNDAY_ALIAS = 3'd7;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_ACT     = 8'b0000_0010,
    S_SET_WR  = 8'b0000_0100,
    S_SH_RD   = 8'b0000_1000,
    S_SH_WR   = 8'b0001_0000,
    S_SC_RD   = 8'b0010_0000,
    S_SC_EVAL = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  // Control registers.
  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      ptr_r, ptr_nxt;
  logic                  cand_v_r, cand_v_nxt;
  logic                  best_found_r, best_found_nxt;
  logic                  out_valid_r;

  // Request capture.
  wanp_pkg::action_t                  act_r;
  logic [wanp_pkg::INDEX_W-1:0]       idx_r;
  wanp_pkg::slot_t                    new_slot_r;
  logic [wanp_pkg::WEEKDAY_W-1:0]     wd_r;
  logic [wanp_pkg::HOUR_W-1:0]        now_h_r;
  logic [wanp_pkg::MINUTE_W-1:0]      now_m_r;
  logic [wanp_pkg::TOD_W-1:0]         now_tod_r;

  // Scan datapath.
  wanp_pkg::status_t                  status_r, status_nxt;
  logic [CNT_W-1:0]                   rd_idx_r, rd_idx_nxt;
  logic signed [wanp_pkg::RAW_W-1:0]  cand_raw_r, cand_raw_nxt;
  logic [wanp_pkg::WEEKDAY_W-1:0]     cand_wd_r, cand_wd_nxt;
  logic [wanp_pkg::HOUR_W-1:0]        cand_hour_r, cand_hour_nxt;
  logic [wanp_pkg::MINUTE_W-1:0]      cand_minute_r, cand_minute_nxt;
  logic [CNT_W-1:0]                   best_idx_r, best_idx_nxt;
  logic [wanp_pkg::WEEKDAY_W-1:0]     best_wd_r, best_wd_nxt;
  logic [wanp_pkg::HOUR_W-1:0]        best_hour_r, best_hour_nxt;
  logic [wanp_pkg::MINUTE_W-1:0]      best_minute_r, best_minute_nxt;
  logic [wanp_pkg::DELTA_W-1:0]       best_delta_r, best_delta_nxt;

  // Output register.
  wanp_pkg::status_t                  o_status_r;
  logic [wanp_pkg::TOTAL_W-1:0]       o_total_r;
  logic                               o_found_r;
  logic [wanp_pkg::INDEX_W-1:0]       o_index_r;
  logic [wanp_pkg::WEEKDAY_W-1:0]     o_wd_r;
  logic [wanp_pkg::HOUR_W-1:0]        o_hour_r;
  logic [wanp_pkg::MINUTE_W-1:0]      o_minute_r;
  logic [wanp_pkg::DELTA_W-1:0]       o_delta_r;

  // Table memory and its ports.
  wanp_pkg::slot_t       mem [ENTRIES];
  wanp_pkg::slot_t       rdata_r;
  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
  wanp_pkg::slot_t       mem_wdata;

  logic                  in_acc;
  logic                  out_ld;
  logic [CMP_W-1:0]      idx_ext, cnt_ext, ptr_inc;
  logic                  idx_bad;

  // Due-time unit signals.
  logic                               ev_early;
  logic [2*wanp_pkg::DAYS_W-1:0]      ev_dbl;
  logic [wanp_pkg::DAYS_W-1:0]        ev_rot;
  logic [wanp_pkg::WEEKDAY_W-1:0]     ev_days;
  logic                               ev_later;
  logic                               ev_due;
  logic [wanp_pkg::WEEKDAY_W:0]       ev_tsum;
  logic [wanp_pkg::DELTA_W-1:0]       cand_delta;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_ld  = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign idx_ext = CMP_W'(idx_r);
  assign cnt_ext = CMP_W'(count_r);
  assign ptr_inc = CMP_W'(ptr_r) + CMP_W'(1);
  assign idx_bad = (idx_ext >= cnt_ext);

  assign in_ch.ready = (state_r == S_IDLE);

  // Shared due-time unit: picks the firing day of the entry just read.
  always_comb begin
    ev_early = (now_h_r < rdata_r.hour) ||
               ((now_h_r == rdata_r.hour) && (now_m_r < rdata_r.minute));
    ev_dbl   = {rdata_r.repeat_days, rdata_r.repeat_days};
    ev_rot   = wanp_pkg::DAYS_W'(ev_dbl >> wd_r);
    ev_days  = '0;
    ev_later = 1'b0;
    // Nearest later weekday with its bit set, scanning down so the lowest wins.
    for (int k = wanp_pkg::DAYS_PER_WEEK - 1; k >= 1; k--) begin
      if (ev_rot[k]) begin
        ev_days  = wanp_pkg::WEEKDAY_W'(k);
        ev_later = 1'b1;
      end
    end
    ev_due = 1'b1;
    if (rdata_r.once) begin
      ev_days = ev_early ? wanp_pkg::WEEKDAY_W'(wanp_pkg::DAYS_PER_WEEK)
                         : wanp_pkg::WEEKDAY_W'(1);
    end else if (ev_rot[0] && ev_early) begin
      ev_days = wanp_pkg::WEEKDAY_W'(wanp_pkg::DAYS_PER_WEEK);
    end else if (!ev_later) begin
      // Only today's bit set means today next week; an empty mask never fires.
      ev_days = wanp_pkg::WEEKDAY_W'(wanp_pkg::DAYS_PER_WEEK);
      ev_due  = ev_rot[0];
    end
    ev_tsum = (wanp_pkg::WEEKDAY_W + 1)'(wd_r) + (wanp_pkg::WEEKDAY_W + 1)'(ev_days);
    if (ev_tsum >= (wanp_pkg::WEEKDAY_W + 1)'(wanp_pkg::DAYS_PER_WEEK)) begin
      ev_tsum = ev_tsum - (wanp_pkg::WEEKDAY_W + 1)'(wanp_pkg::DAYS_PER_WEEK);
    end
    cand_wd_nxt     = ev_tsum[wanp_pkg::WEEKDAY_W-1:0];
    cand_hour_nxt   = rdata_r.hour;
    cand_minute_nxt = rdata_r.minute;
    cand_raw_nxt    = $signed(wanp_pkg::RAW_W'(wanp_pkg::day_offset(ev_days)))
                    + $signed(wanp_pkg::RAW_W'(wanp_pkg::tod(rdata_r.hour, rdata_r.minute)))
                    - $signed(wanp_pkg::RAW_W'(now_tod_r));
  end

  // Week wrap of the raw difference, which stays within one week either way.
  always_comb begin
    if (cand_raw_r < 0) begin
      cand_delta = wanp_pkg::DELTA_W'(cand_raw_r + WEEK_S);
    end else if (cand_raw_r >= WEEK_S) begin
      cand_delta = wanp_pkg::DELTA_W'(cand_raw_r - WEEK_S);
    end else begin
      cand_delta = wanp_pkg::DELTA_W'(cand_raw_r);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    ptr_nxt         = ptr_r;
    cand_v_nxt      = cand_v_r;
    best_found_nxt  = best_found_r;
    status_nxt      = status_r;
    rd_idx_nxt      = rd_idx_r;
    best_idx_nxt    = best_idx_r;
    best_wd_nxt     = best_wd_r;
    best_hour_nxt   = best_hour_r;
    best_minute_nxt = best_minute_r;
    best_delta_nxt  = best_delta_r;
    mem_we          = 1'b0;
    mem_waddr       = count_r[ADDR_W-1:0];
    mem_wdata       = new_slot_r;
    mem_re          = 1'b0;
    mem_raddr       = ptr_r[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_ACT;
        end
      end

      S_ACT: begin
        status_nxt     = wanp_pkg::STATUS_OK;
        best_found_nxt = 1'b0;
        cand_v_nxt     = 1'b0;
        ptr_nxt        = '0;
        state_nxt      = S_SC_RD;
        case (act_r)
          wanp_pkg::ACT_ADD: begin
            if (count_r >= CNT_W'(ENTRIES)) begin
              status_nxt = wanp_pkg::STATUS_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = count_r[ADDR_W-1:0];
              mem_wdata = new_slot_r;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          wanp_pkg::ACT_DELETE: begin
            if (idx_bad) begin
              status_nxt = wanp_pkg::STATUS_BAD_INDEX;
            end else if ((idx_ext + CMP_W'(1)) < cnt_ext) begin
              ptr_nxt   = idx_ext[CNT_W-1:0];
              state_nxt = S_SH_RD;
            end else begin
              count_nxt = count_r - CNT_W'(1);
            end
          end
          wanp_pkg::ACT_SET_ENABLE: begin
            if (idx_bad) begin
              status_nxt = wanp_pkg::STATUS_BAD_INDEX;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = idx_ext[ADDR_W-1:0];
              state_nxt = S_SET_WR;
            end
          end
          default: begin
          end
        endcase
      end

      // Write back the entry with its new enable bit.
      S_SET_WR: begin
        mem_we           = 1'b1;
        mem_waddr        = idx_ext[ADDR_W-1:0];
        mem_wdata        = rdata_r;
        mem_wdata.enable = new_slot_r.enable;
        ptr_nxt          = '0;
        state_nxt        = S_SC_RD;
      end

      // Shift-down after a delete: read the entry above, then write it here.
      S_SH_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_inc[ADDR_W-1:0];
        state_nxt = S_SH_WR;
      end

      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[ADDR_W-1:0];
        mem_wdata = rdata_r;
        if ((ptr_inc + CMP_W'(1)) < cnt_ext) begin
          ptr_nxt   = ptr_inc[CNT_W-1:0];
          state_nxt = S_SH_RD;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          ptr_nxt   = '0;
          state_nxt = S_SC_RD;
        end
      end

      // Fold the last candidate into the best, then read the next entry.
      S_SC_RD: begin
        if (cand_v_r && (!best_found_r || (cand_delta <= best_delta_r))) begin
          best_found_nxt  = 1'b1;
          best_idx_nxt    = rd_idx_r;
          best_wd_nxt     = cand_wd_r;
          best_hour_nxt   = cand_hour_r;
          best_minute_nxt = cand_minute_r;
          best_delta_nxt  = cand_delta;
        end
        cand_v_nxt = 1'b0;
        if (ptr_r < count_r) begin
          mem_re     = 1'b1;
          mem_raddr  = ptr_r[ADDR_W-1:0];
          rd_idx_nxt = ptr_r;
          ptr_nxt    = ptr_r + CNT_W'(1);
          state_nxt  = S_SC_EVAL;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_SC_EVAL: begin
        cand_v_nxt = rdata_r.enable && ev_due;
        state_nxt  = S_SC_RD;
      end

      S_DONE: begin
        if (out_ld) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      ptr_r        <= '0;
      cand_v_r     <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      ptr_r        <= ptr_nxt;
      cand_v_r     <= cand_v_nxt;
      best_found_r <= best_found_nxt;
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture and datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r                  <= wanp_pkg::action_t'(in_ch.action);
      idx_r                  <= in_ch.entry_index;
      new_slot_r.hour        <= in_ch.new_hour;
      new_slot_r.minute      <= in_ch.new_minute;
      new_slot_r.repeat_days <= in_ch.new_repeat_days;
      new_slot_r.once        <= in_ch.new_once;
      new_slot_r.enable      <= in_ch.enable_flag;
      // Weekday seven counts as Sunday.
      wd_r      <= (in_ch.now_weekday == SUNDAY_ALIAS) ? '0 : in_ch.now_weekday;
      now_h_r   <= in_ch.now_hour;
      now_m_r   <= in_ch.now_minute;
      now_tod_r <= wanp_pkg::tod(in_ch.now_hour, in_ch.now_minute);
    end
    status_r      <= status_nxt;
    rd_idx_r      <= rd_idx_nxt;
    best_idx_r    <= best_idx_nxt;
    best_wd_r     <= best_wd_nxt;
    best_hour_r   <= best_hour_nxt;
    best_minute_r <= best_minute_nxt;
    best_delta_r  <= best_delta_nxt;
    if (state_r == S_SC_EVAL) begin
      cand_raw_r    <= cand_raw_nxt;
      cand_wd_r     <= cand_wd_nxt;
      cand_hour_r   <= cand_hour_nxt;
      cand_minute_r <= cand_minute_nxt;
    end
  end

  // Result register; the next-alarm fields are zero when nothing is due.
  always_ff @(posedge clk) begin
    if (out_ld) begin
      o_status_r <= status_r;
      o_total_r  <= wanp_pkg::TOTAL_W'(count_r);
      o_found_r  <= best_found_r;
      o_index_r  <= best_found_r ? wanp_pkg::INDEX_W'(best_idx_r) : '0;
      o_wd_r     <= best_found_r ? best_wd_r : '0;
      o_hour_r   <= best_found_r ? best_hour_r : '0;
      o_minute_r <= best_found_r ? best_minute_r : '0;
      o_delta_r  <= best_found_r ? best_delta_r : '0;
    end
  end

  // Alarm table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = o_status_r;
  assign out_ch.alarm_total   = o_total_r;
  assign out_ch.next_found    = o_found_r;
  assign out_ch.next_index    = o_index_r;
  assign out_ch.next_weekday  = o_wd_r;
  assign out_ch.next_hour     = o_hour_r;
  assign out_ch.next_minute   = o_minute_r;
  assign out_ch.minutes_until = o_delta_r;

  // The table never holds more alarms than it has entries.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("alarm count above table depth");

  // One request changes the count by at most one, and only in one step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == $past(count_r)) || (count_r == $past(count_r) + CNT_W'(1)) ||
    (count_r + CNT_W'(1) == $past(count_r)))
    else $error("alarm count jumped");

  // During the scan the best candidate points at a held entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SC_RD) || (state_r == S_SC_EVAL)) && best_found_r
      |-> (best_idx_r < count_r))
    else $error("best index outside the table");

  // An accepted request starts the action step next.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_ACT))
    else $error("accepted request did not start");

  // A finished request always shows up as a valid result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |=> (out_ch.valid && (state_r == S_IDLE)))
    else $error("finished result not presented");

endmodule

/* tb/sv/alarm_picker_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the alarm picker, keeps its own copy of the
// alarm table, works out the report each accepted request should produce
// and compares every accepted report with the oldest one still waiting.
module alarm_picker_checker #(
  parameter int ENTRIES = wanp_pkg::ENTRIES_DEFAULT
) (
  input  logic  clk,
  input  logic  rst_n,
  wanp_in_if    in_mon,
  wanp_out_if   out_mon,
  output int    mismatches,
  output int    reports_waiting,
  output int    reports_checked,
  output int    full_seen,
  output int    bad_index_seen,
  output int    due_now_seen
);
  import wanp_pkg::*;

  typedef struct packed {
    status_t               status;
    logic [TOTAL_W-1:0]    alarm_total;
    logic                  next_found;
    logic [INDEX_W-1:0]    next_index;
    logic [WEEKDAY_W-1:0]  next_weekday;
    logic [HOUR_W-1:0]     next_hour;
    logic [MINUTE_W-1:0]   next_minute;
    logic [DELTA_W-1:0]    minutes_until;
  } alarm_report_t;

  // Shadow copy of the alarm table and its fill level.
  slot_t         alarm_store [ENTRIES];
  int            alarm_used;
  alarm_report_t expected_reports [$];
  alarm_report_t oldest;
  slot_t         add_slot;

  initial begin
    mismatches      = 0;
    reports_waiting = 0;
    reports_checked = 0;
    full_seen       = 0;
    bad_index_seen  = 0;
    due_now_seen    = 0;
    alarm_used      = 0;
  end

  // Works out on which weekday an alarm fires next and how many minutes
  // away that is. Returns 0 when the alarm can never fire.
  function automatic bit next_firing(input slot_t s, input int wd, input int h,
                                     input int m, output int fire_day,
                                     output int lead);
    bit early;
    bit hit;
    int target;
    int days;
    int v;
    early = (h < int'(s.hour)) || (h == int'(s.hour) && m < int'(s.minute));
    hit = 1'b1;
    target = wd;
    if (s.once) begin
      // A one-shot alarm ignores its mask: later today or else tomorrow.
      target = early ? wd : (wd + 1) % DAYS_PER_WEEK;
    end else begin
      hit = 1'b0;
      if (s.repeat_days[wd] && early) begin
        hit = 1'b1;
      end else begin
        for (int k = 1; k < DAYS_PER_WEEK; k++) begin
          if (!hit && s.repeat_days[(wd + k) % DAYS_PER_WEEK]) begin
            target = (wd + k) % DAYS_PER_WEEK;
            hit = 1'b1;
          end
        end
        // Only today is set and its time has passed: same day next week.
        if (!hit && s.repeat_days[wd]) begin
          hit = 1'b1;
        end
      end
    end
    fire_day = target;
    lead = 0;
    if (hit) begin
      days = (target == wd) ? DAYS_PER_WEEK : (target + DAYS_PER_WEEK - wd) % DAYS_PER_WEEK;
      v = days * DAY_MINUTES + int'(s.hour) * 60 + int'(s.minute) - (h * 60 + m);
      v = v % WEEK_MINUTES;
      if (v < 0) begin
        v = v + WEEK_MINUTES;
      end
      lead = v;
    end
    return hit;
  endfunction

  // Applies one request to the shadow table and builds its report.
  function automatic alarm_report_t apply_request(input action_t act,
                                                  input logic [INDEX_W-1:0] idx,
                                                  input slot_t new_slot,
                                                  input logic [WEEKDAY_W-1:0] wd_raw,
                                                  input logic [HOUR_W-1:0] h,
                                                  input logic [MINUTE_W-1:0] m);
    alarm_report_t rep;
    int  wd;
    bit  found;
    int  best_idx;
    int  best_day;
    int  best_lead;
    int  fire_day;
    int  lead;
    rep = '0;
    rep.status = STATUS_OK;
    wd = (wd_raw == 3'd7) ? 0 : int'(wd_raw);
    found = 1'b0;
    best_idx = 0;
    best_day = 0;
    best_lead = 0;

    case (act)
      ACT_ADD: begin
        if (alarm_used >= ENTRIES) begin
          rep.status = STATUS_FULL;
        end else begin
          alarm_store[alarm_used] = new_slot;
          alarm_used++;
        end
      end
      ACT_DELETE: begin
        if (int'(idx) >= alarm_used) begin
          rep.status = STATUS_BAD_INDEX;
        end else begin
          for (int i = int'(idx); i + 1 < alarm_used; i++) begin
            alarm_store[i] = alarm_store[i + 1];
          end
          alarm_used--;
        end
      end
      ACT_SET_ENABLE: begin
        if (int'(idx) >= alarm_used) begin
          rep.status = STATUS_BAD_INDEX;
        end else begin
          alarm_store[idx].enable = new_slot.enable;
        end
      end
      default: begin
      end
    endcase

    // Scan the enabled alarms; on equal lead time the later index wins.
    for (int i = 0; i < alarm_used; i++) begin
      if (alarm_store[i].enable && next_firing(alarm_store[i], wd, int'(h), int'(m),
                                               fire_day, lead)) begin
        if (!found || lead <= best_lead) begin
          found = 1'b1;
          best_idx = i;
          best_day = fire_day;
          best_lead = lead;
        end
      end
    end

    rep.alarm_total = TOTAL_W'(alarm_used);
    rep.next_found = found;
    if (found) begin
      rep.next_index    = INDEX_W'(best_idx);
      rep.next_weekday  = WEEKDAY_W'(best_day);
      rep.next_hour     = alarm_store[best_idx].hour;
      rep.next_minute   = alarm_store[best_idx].minute;
      rep.minutes_until = DELTA_W'(best_lead);
    end
    return rep;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Requests and reports are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        add_slot.hour        = in_mon.new_hour;
        add_slot.minute      = in_mon.new_minute;
        add_slot.repeat_days = in_mon.new_repeat_days;
        add_slot.once        = in_mon.new_once;
        add_slot.enable      = in_mon.enable_flag;
        expected_reports.push_back(apply_request(action_t'(in_mon.action),
                                                 in_mon.entry_index, add_slot,
                                                 in_mon.now_weekday, in_mon.now_hour,
                                                 in_mon.now_minute));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: report with nothing outstanding, expected none, actual status %0d",
                   $time, out_mon.status);
          mismatches++;
        end else begin
          oldest = expected_reports.pop_front();
          check_field("status",        16'(oldest.status),        16'(out_mon.status));
          check_field("alarm_total",   16'(oldest.alarm_total),   16'(out_mon.alarm_total));
          check_field("next_found",    16'(oldest.next_found),    16'(out_mon.next_found));
          check_field("next_index",    16'(oldest.next_index),    16'(out_mon.next_index));
          check_field("next_weekday",  16'(oldest.next_weekday),  16'(out_mon.next_weekday));
          check_field("next_hour",     16'(oldest.next_hour),     16'(out_mon.next_hour));
          check_field("next_minute",   16'(oldest.next_minute),   16'(out_mon.next_minute));
          check_field("minutes_until", 16'(oldest.minutes_until), 16'(out_mon.minutes_until));
          reports_checked++;
          if (oldest.status == STATUS_FULL) begin
            full_seen++;
          end
          if (oldest.status == STATUS_BAD_INDEX) begin
            bad_index_seen++;
          end
          if (oldest.next_found && oldest.minutes_until == '0) begin
            due_now_seen++;
          end
        end
      end
      reports_waiting = expected_reports.size();
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import wanp_pkg::*;

  localparam int RANDOM_REQUESTS = 1500;
  localparam int LIMIT_CYCLES    = 400000;
  localparam int DRAIN_CYCLES    = 64;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct {
    action_t               act;
    logic [INDEX_W-1:0]    idx;
    logic [HOUR_W-1:0]     nh;
    logic [MINUTE_W-1:0]   nm;
    logic [DAYS_W-1:0]     days;
    logic                  once;
    logic                  en;
    logic [WEEKDAY_W-1:0]  wd;
    logic [HOUR_W-1:0]     h;
    logic [MINUTE_W-1:0]   m;
  } alarm_request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int hold_off_asked = 0;
  int hold_off_served = 0;
  int table_fill = 0;
  int sent_per_action [4] = '{0, 0, 0, 0};
  int cycle_count = 0;

  int mismatches;
  int reports_waiting;
  int reports_checked;
  int full_seen;
  int bad_index_seen;
  int due_now_seen;

  always #5 clk = ~clk;

  wanp_in_if  in_ch ();
  wanp_out_if out_ch ();

  weekly_alarm_next_picker_top #(
    .ENTRIES(ENTRIES_DEFAULT)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  alarm_picker_checker #(
    .ENTRIES(ENTRIES_DEFAULT)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .mismatches      (mismatches),
    .reports_waiting (reports_waiting),
    .reports_checked (reports_checked),
    .full_seen       (full_seen),
    .bad_index_seen  (bad_index_seen),
    .due_now_seen    (due_now_seen)
  );

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d reports outstanding.", cycle_count,
               reports_waiting);
      $display("** weekly_alarm_next_picker_top: FAILED **");
      $finish;
    end
  end

  // Report receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_served != hold_off_asked) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_served++;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        @(negedge clk);
      end
    end
  end

  // Alarm times drawn often from a tiny pool so that ties and alarms due
  // this very minute come up; now and then outside the day's range.
  function automatic logic [HOUR_W-1:0] pick_hour();
    int r;
    r = $urandom_range(99);
    if (r < 20) begin
      return $urandom_range(1) ? HOUR_W'(7) : HOUR_W'(23);
    end else if (r < 30) begin
      return HOUR_W'($urandom_range(31));
    end
    return HOUR_W'($urandom_range(23));
  endfunction

  function automatic logic [MINUTE_W-1:0] pick_minute();
    int r;
    r = $urandom_range(99);
    if (r < 20) begin
      return $urandom_range(1) ? MINUTE_W'(0) : MINUTE_W'(59);
    end else if (r < 30) begin
      return MINUTE_W'($urandom_range(63));
    end
    return MINUTE_W'($urandom_range(59));
  endfunction

  // Random requests alternate between growing and shrinking the table in
  // stretches of a hundred, so both the full and the empty table recur.
  function automatic alarm_request_t make_random_request(input int n);
    alarm_request_t r;
    bit grow;
    int pick;
    grow = ((n / 100) % 2) == 0;
    pick = $urandom_range(99);
    if (pick < (grow ? 50 : 15)) begin
      r.act = ACT_ADD;
    end else if (pick < (grow ? 65 : 60)) begin
      r.act = ACT_DELETE;
    end else if (pick < 80) begin
      r.act = ACT_SET_ENABLE;
    end else begin
      r.act = ACT_QUERY;
    end
    if (table_fill > 0 && $urandom_range(99) < 85) begin
      r.idx = INDEX_W'($urandom_range(table_fill - 1));
    end else begin
      r.idx = INDEX_W'($urandom_range(15));
    end
    r.nh = pick_hour();
    r.nm = pick_minute();
    pick = $urandom_range(99);
    if (pick < 35) begin
      r.days = DAYS_W'(1 << $urandom_range(6));
    end else if (pick < 45) begin
      r.days = '0;
    end else if (pick < 55) begin
      r.days = '1;
    end else begin
      r.days = DAYS_W'($urandom_range(127));
    end
    r.once = ($urandom_range(99) < 30);
    r.en   = ($urandom_range(99) < 80);
    r.wd   = WEEKDAY_W'($urandom_range(7));
    r.h    = pick_hour();
    r.m    = pick_minute();
    return r;
  endfunction

  // Offers one request from a falling edge and returns at the falling edge
  // after it was taken; valid stays high for a back-to-back request.
  task automatic send_request(input alarm_request_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.action          <= r.act;
    in_ch.entry_index     <= r.idx;
    in_ch.new_hour        <= r.nh;
    in_ch.new_minute      <= r.nm;
    in_ch.new_repeat_days <= r.days;
    in_ch.new_once        <= r.once;
    in_ch.enable_flag     <= r.en;
    in_ch.now_weekday     <= r.wd;
    in_ch.now_hour        <= r.h;
    in_ch.now_minute      <= r.m;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    @(negedge clk);
    // Track the fill level only to aim indexes at live entries.
    if (r.act == ACT_ADD && table_fill < ENTRIES_DEFAULT) begin
      table_fill++;
    end else if (r.act == ACT_DELETE && int'(r.idx) < table_fill) begin
      table_fill--;
    end
    sent_per_action[int'(r.act)]++;
  endtask

  task automatic offer(input action_t act, input int idx, input int nh, input int nm,
                       input int days, input int once, input int en, input int wd,
                       input int h, input int m);
    alarm_request_t r;
    r.act  = act;
    r.idx  = INDEX_W'(idx);
    r.nh   = HOUR_W'(nh);
    r.nm   = MINUTE_W'(nm);
    r.days = DAYS_W'(days);
    r.once = once[0];
    r.en   = en[0];
    r.wd   = WEEKDAY_W'(wd);
    r.h    = HOUR_W'(h);
    r.m    = MINUTE_W'(m);
    send_request(r);
  endtask

  initial begin
    alarm_request_t r;
    in_ch.valid           = 1'b0;
    in_ch.action          = ACT_QUERY;
    in_ch.entry_index     = '0;
    in_ch.new_hour        = '0;
    in_ch.new_minute      = '0;
    in_ch.new_repeat_days = '0;
    in_ch.new_once        = 1'b0;
    in_ch.enable_flag     = 1'b0;
    in_ch.now_weekday     = '0;
    in_ch.now_hour        = '0;
    in_ch.now_minute      = '0;

    // Synchronous reset.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    src_idle_pct  = 9;
    sink_idle_pct = 52;

    // Directed: empty table, day-choice corner cases, ties, odd times,
    // full table, bad indexes and shifting deletes.
    offer(ACT_QUERY,      0,  0,  0,   0, 0, 0, 0,  0,  0);
    offer(ACT_DELETE,     0,  0,  0,   0, 0, 0, 0,  0,  0);
    offer(ACT_SET_ENABLE, 15, 0,  0,   0, 0, 1, 0,  0,  0);
    // One-shot at exactly now fires tomorrow.
    offer(ACT_ADD,        0,  7,  0,   0, 1, 1, 1,  7,  0);
    // Only today in the mask and its time passed: next week.
    offer(ACT_ADD,        0,  6,  30,  8, 0, 1, 3,  8,  0);
    // Only today in the mask at exactly now: due in zero minutes.
    offer(ACT_ADD,        0,  9,  15,  4, 0, 1, 2,  9,  15);
    // Empty mask is never due.
    offer(ACT_ADD,        0,  10, 0,   0, 0, 1, 2,  9,  0);
    // Same alarm again: the later index wins the tie.
    offer(ACT_ADD,        0,  9,  15,  4, 0, 1, 2,  9,  15);
    // Out-of-range time, full mask, disabled; weekday seven reads as Sunday.
    offer(ACT_ADD,        0,  31, 63, 127, 0, 0, 7, 31, 63);
    offer(ACT_SET_ENABLE, 5,  0,  0,   0, 0, 1, 7, 23, 59);
    offer(ACT_QUERY,      0,  0,  0,   0, 0, 0, 6,  0,  0);
    // One-shot with a full mask still goes by time alone.
    offer(ACT_ADD,        0,  23, 59, 127, 1, 1, 6, 23, 59);
    offer(ACT_ADD,        0,  0,  0,   1, 0, 1, 0,  0,  0);
    offer(ACT_ADD,        0,  12, 30, 64, 0, 1, 5, 12, 29);
    offer(ACT_ADD,        0,  0,  59, 42, 1, 0, 4, 20, 0);
    // Table holds ten now; this add is refused.
    offer(ACT_ADD,        0,  1,  1,   1, 0, 1, 0,  0,  0);
    offer(ACT_SET_ENABLE, 10, 0,  0,   0, 0, 1, 0,  0,  0);
    offer(ACT_SET_ENABLE, 0,  0,  0,   0, 0, 0, 1,  7,  0);
    offer(ACT_DELETE,     0,  0,  0,   0, 0, 0, 2,  9,  15);
    offer(ACT_DELETE,     8,  0,  0,   0, 0, 0, 2,  9,  15);
    offer(ACT_DELETE,     15, 0,  0,   0, 0, 0, 3,  0,  0);
    offer(ACT_QUERY,      0,  0,  0,   0, 0, 0, 0,  0,  0);
    offer(ACT_SET_ENABLE, 3,  0,  0,   0, 0, 0, 5, 12, 0);

    // Random part in three idle mixes; the last one opens with a long
    // receiver hold-off while requests keep coming.
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 9 : (ph == 1) ? 52 : 0;
      sink_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 9 : 0;
      if (ph == 2) begin
        hold_off_asked++;
      end
      for (int n = 0; n < RANDOM_REQUESTS / 3; n++) begin
        r = make_random_request(n);
        send_request(r);
      end
    end
    in_ch.valid <= 1'b0;

    while (reports_waiting != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d requests: %0d add, %0d delete, %0d set-enable, %0d query.",
             sent_per_action[0] + sent_per_action[1] + sent_per_action[2] +
             sent_per_action[3], sent_per_action[ACT_ADD], sent_per_action[ACT_DELETE],
             sent_per_action[ACT_SET_ENABLE], sent_per_action[ACT_QUERY]);
    $display("Checked %0d reports: %0d refused adds, %0d bad indexes, %0d due this minute.",
             reports_checked, full_seen, bad_index_seen, due_now_seen);
    if (mismatches == 0) begin
      $display("** weekly_alarm_next_picker_top: PASSED **");
    end else begin
      $display("** weekly_alarm_next_picker_top: FAILED **");
    end
    $finish;
  end

endmodule
